/* src/hno_pkg.sv */
// Shared types, constants and command codes of the heightfield normal/occlusion unit.
// No dependencies; imported by hno_ctrl, hno_dpath and the top level.
package hno_pkg;

  localparam int MAX_COLS    = 1024;
  localparam int MAX_ROWS    = 4096;
  localparam int HEIGHT_BITS = 16;
  localparam int WIN_DEPTH   = 2 * MAX_COLS + 3;
  localparam int WIN_AW      = $clog2(WIN_DEPTH);
  localparam int ADDR_W      = 4;

  // magnitude, square and divider widths
  localparam int MAG_W  = 25;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int LEN_W  = 52;
  localparam int ROOT_W = 26;
  localparam int NUM_W  = 42;
  localparam int REM_W  = ROOT_W + 1;
  localparam int SUM_W  = 19;

  localparam logic [MAG_W-1:0] Y_MAG   = MAG_W'(1) << (HEIGHT_BITS + 1);
  localparam logic [LEN_W-1:0] Y_SQ    = LEN_W'(1) << (2 * (HEIGHT_BITS + 1));
  localparam logic [LEN_W-1:0] SQ_BIT0 = LEN_W'(1) << (LEN_W - 2);
  localparam logic [NUM_W-1:0] COMP_SAT = NUM_W'(32767);
  localparam logic [NUM_W-1:0] OCC_SAT  = NUM_W'(65535);
  localparam logic [ROOT_W-1:0] OCC_DEN = ROOT_W'(14);
  localparam logic [NUM_W-1:0] OCC_BIAS = NUM_W'(7);

  // input op codes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // register indexes
  localparam logic [1:0] REG_COLS  = 2'd0;
  localparam logic [1:0] REG_ROWS  = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;

  // neighbor read order
  localparam logic [3:0] NB_C  = 4'd0;
  localparam logic [3:0] NB_W  = 4'd1;
  localparam logic [3:0] NB_E  = 4'd2;
  localparam logic [3:0] NB_N  = 4'd3;
  localparam logic [3:0] NB_S  = 4'd4;
  localparam logic [3:0] NB_NW = 4'd5;
  localparam logic [3:0] NB_NE = 4'd6;
  localparam logic [3:0] NB_SW = 4'd7;
  localparam logic [3:0] NB_SE = 4'd8;

  // divider jobs
  localparam logic [1:0] DIV_X   = 2'd0;
  localparam logic [1:0] DIV_Y   = 2'd1;
  localparam logic [1:0] DIV_Z   = 2'd2;
  localparam logic [1:0] DIV_OCC = 2'd3;

  // sequencer phase lengths
  localparam logic [5:0] READ_END = 6'd9;
  localparam logic [5:0] MUL_END  = 6'd3;
  localparam logic [5:0] SQRT_END = 6'(LEN_W / 2);
  localparam logic [5:0] DIV_END  = 6'(NUM_W + 1);

  typedef struct packed {
    logic        op;
    logic [15:0] sample_height;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        vertex_row;
    logic [9:0]         vertex_col;
    logic signed [15:0] normal_x;
    logic [14:0]        normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        occlusion;
    logic               last_vertex;
  } out_item_t;

  typedef struct packed {
    logic       rd_en;
    logic [3:0] rd_sel;
    logic       cap_en;
    logic [3:0] cap_sel;
    logic       mul_en;
    logic [1:0] mul_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic [1:0] div_sel;
    logic       load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic out_full;
  } dp_status_t;

endpackage

/* src/hno_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hno_ram #(
  parameter int Width = 16,
  parameter int Depth = 2051
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* src/hno_ctrl.sv */
// Sequencer of the heightfield normal/occlusion unit: one-hot phase machine.
// Depends on hno_pkg; drives the datapath through ctrl_cmd_t.
module hno_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_acc_i,
  input  hno_pkg::dp_status_t st_i,
  output hno_pkg::ctrl_cmd_t  cmd_o,
  output logic                idle_o
);
  import hno_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_SQRT = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [1:0]  dsel_q, dsel_d;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    dsel_d        = dsel_q;
    cmd_o         = '0;
    cmd_o.rd_sel  = cnt_q[3:0];
    cmd_o.cap_sel = cnt_q[3:0] - 4'd1;
    cmd_o.mul_step = cnt_q[1:0];
    cmd_o.div_sel = dsel_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc_i && st_i.emit_req) begin
          state_d = ST_READ;
          cnt_d   = '0;
        end
      end
      ST_READ: begin
        cmd_o.rd_en  = (cnt_q < READ_END);
        cmd_o.cap_en = (cnt_q != '0);
        if (cnt_q == READ_END) begin
          state_d = ST_MUL;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        if (cnt_q == MUL_END) begin
          state_d = ST_SQRT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_init = (cnt_q == '0);
        cmd_o.sqrt_step = (cnt_q != '0);
        if (cnt_q == SQRT_END) begin
          state_d = ST_DIV;
          cnt_d   = '0;
          dsel_d  = DIV_X;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_DIV: begin
        cmd_o.div_init  = (cnt_q == '0);
        cmd_o.div_step  = (cnt_q != '0) && (cnt_q < DIV_END);
        cmd_o.div_store = (cnt_q == DIV_END);
        if (cnt_q == DIV_END) begin
          cnt_d = '0;
          if (dsel_q == DIV_OCC) begin
            state_d = ST_OUT;
          end else begin
            dsel_d = dsel_q + 2'd1;
          end
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_OUT: begin
        if (!st_i.out_full) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      dsel_q  <= DIV_X;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      dsel_q  <= dsel_d;
    end
  end

  assign idle_o = (state_q == ST_IDLE);

endmodule

/* src/hno_dpath.sv */
// Datapath: config registers, sample window RAM, neighbor fetch, multiplier,
// bit-serial square root and shared restoring divider, output register.
// Depends on hno_pkg and hno_ram.
module hno_dpath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [hno_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  input  logic                      in_acc_i,
  input  hno_pkg::in_item_t         in_item_i,
  input  logic                      out_stall_i,
  input  hno_pkg::ctrl_cmd_t        cmd_i,
  output hno_pkg::dp_status_t       st_o,
  output logic                      out_valid_o,
  output hno_pkg::out_item_t        out_item_o
);
  import hno_pkg::*;

  // configuration and stream position
  logic [10:0] cols_q;
  logic [12:0] rows_q;
  logic [7:0]  scale_q;
  logic [22:0] taken_q;
  logic [WIN_AW-1:0] wr_addr_q, out_addr_q;
  logic [11:0] out_row_q;
  logic [9:0]  out_col_q;
  logic        fin_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic [10:0] cols_eff;
  logic [12:0] rows_eff;
  logic [22:0] total;
  logic        push_ok, cfg_wr, cfg_hit, is_last;
  logic [12:0] row_max;
  logic [10:0] col_max;

  assign cols_eff = (cols_q < 11'd2) ? 11'd2 :
                    (cols_q > 11'(MAX_COLS)) ? 11'(MAX_COLS) : cols_q;
  assign rows_eff = (rows_q < 13'd2) ? 13'd2 :
                    (rows_q > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : rows_q;
  assign total    = 23'(cols_eff) * 23'(rows_eff);
  assign row_max  = rows_eff - 13'd1;
  assign col_max  = cols_eff - 11'd1;

  assign push_ok = !fin_q && (in_item_i.op == OP_PUSH) && (taken_q < total);
  always_comb begin
    st_o.out_full = out_valid_q && out_stall_i;
    if (fin_q) begin
      st_o.emit_req = 1'b0;
    end else if (push_ok) begin
      st_o.emit_req = (taken_q >= 23'(cols_eff) + 23'd1);
    end else begin
      st_o.emit_req = (taken_q == total);
    end
  end

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_hit = (paddr[3:2] == REG_COLS) || (paddr[3:2] == REG_ROWS) ||
                   (paddr[3:2] == REG_SCALE);
  assign is_last = ({1'b0, out_row_q} == row_max) && ({1'b0, out_col_q} == col_max);

  always_comb begin
    unique case (paddr[3:2])
      REG_COLS:  prdata = {21'd0, cols_q};
      REG_ROWS:  prdata = {19'd0, rows_q};
      REG_SCALE: prdata = {24'd0, scale_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q      <= 11'd2;
      rows_q      <= 13'd2;
      scale_q     <= 8'd8;
      taken_q     <= '0;
      wr_addr_q   <= '0;
      out_addr_q  <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result may load in the cycle the waiting one leaves
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr && cfg_hit) begin
        unique case (paddr[3:2])
          REG_COLS:  cols_q  <= pwdata[10:0];
          REG_ROWS:  rows_q  <= pwdata[12:0];
          REG_SCALE: scale_q <= pwdata[7:0];
          default:   ;
        endcase
        taken_q    <= '0;
        wr_addr_q  <= '0;
        out_addr_q <= '0;
        out_row_q  <= '0;
        out_col_q  <= '0;
        fin_q      <= 1'b0;
      end else begin
        if (in_acc_i && push_ok) begin
          taken_q   <= taken_q + 23'd1;
          wr_addr_q <= (wr_addr_q == WIN_AW'(WIN_DEPTH - 1)) ? '0 : wr_addr_q + WIN_AW'(1);
        end
        if (cmd_i.load_out) begin
          if (is_last) begin
            fin_q <= 1'b1;
          end else begin
            out_addr_q <= (out_addr_q == WIN_AW'(WIN_DEPTH - 1)) ? '0 :
                          out_addr_q + WIN_AW'(1);
            if ({1'b0, out_col_q} == col_max) begin
              out_col_q <= '0;
              out_row_q <= out_row_q + 12'd1;
            end else begin
              out_col_q <= out_col_q + 10'd1;
            end
          end
        end
      end
    end
  end

  // neighbor address: clamped row/col step, modulo the window depth
  logic signed [1:0]  dr, dc;
  logic signed [13:0] off, asum, afix;
  logic [WIN_AW-1:0]  raddr;
  logic [15:0]        rdata;

  always_comb begin
    dr = 2'sd0;
    dc = 2'sd0;
    unique case (cmd_i.rd_sel)
      NB_N, NB_NW, NB_NE: dr = (out_row_q != '0) ? -2'sd1 : 2'sd0;
      NB_S, NB_SW, NB_SE: dr = ({1'b0, out_row_q} != row_max) ? 2'sd1 : 2'sd0;
      default: dr = 2'sd0;
    endcase
    unique case (cmd_i.rd_sel)
      NB_W, NB_NW, NB_SW: dc = (out_col_q != '0) ? -2'sd1 : 2'sd0;
      NB_E, NB_NE, NB_SE: dc = ({1'b0, out_col_q} != col_max) ? 2'sd1 : 2'sd0;
      default: dc = 2'sd0;
    endcase
    off = 14'sd0;
    if (dr == 2'sd1) begin
      off = $signed({3'b0, cols_eff});
    end else if (dr == -2'sd1) begin
      off = -$signed({3'b0, cols_eff});
    end
    asum = $signed({2'b0, out_addr_q}) + off + 14'(dc);
    if (asum < 14'sd0) begin
      afix = asum + 14'(WIN_DEPTH);
    end else if (asum >= 14'(WIN_DEPTH)) begin
      afix = asum - 14'(WIN_DEPTH);
    end else begin
      afix = asum;
    end
    raddr = afix[WIN_AW-1:0];
  end

  hno_ram #(.Width(HEIGHT_BITS), .Depth(WIN_DEPTH)) u_win (
    .clk_i   (clk_i),
    .we_i    (in_acc_i && push_ok),
    .waddr_i (wr_addr_q),
    .wdata_i (in_item_i.sample_height),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // payload registers
  logic [15:0]        hc_q, hw_q, he_q, hn_q, hs_q;
  logic [SUM_W-1:0]   sum_q;
  logic [MAG_W-1:0]   mx_q, mz_q;
  logic               negx_q, negz_q;
  logic [SQ_W-1:0]    sq_q;
  logic [LEN_W-1:0]   len_q, sv_q, sres_q, sbit_q;
  logic [NUM_W-1:0]   quo_q;
  logic [ROOT_W-1:0]  rem_q, den_q;
  logic signed [15:0] nx_q, nz_q;
  logic [14:0]        ny_q;
  logic [15:0]        occ_q;

  logic signed [16:0] dx, dz;
  logic [15:0]        ax, az;
  logic [23:0]        px, pz;
  logic               col_in, row_in;
  logic [LEN_W-1:0]   strial;
  logic [ROOT_W-1:0]  root, half;
  logic [REM_W-1:0]   dtmp;
  logic               dge;
  logic [14:0]        satc;

  assign dx     = $signed({1'b0, he_q}) - $signed({1'b0, hw_q});
  assign dz     = $signed({1'b0, hn_q}) - $signed({1'b0, hs_q});
  assign ax     = (dx < 17'sd0) ? 16'(-dx) : 16'(dx);
  assign az     = (dz < 17'sd0) ? 16'(-dz) : 16'(dz);
  assign px     = ax * scale_q;
  assign pz     = az * scale_q;
  assign col_in = (out_col_q != '0) && ({1'b0, out_col_q} != col_max);
  assign row_in = (out_row_q != '0) && ({1'b0, out_row_q} != row_max);
  assign strial = sres_q + sbit_q;
  assign root   = sres_q[ROOT_W-1:0];
  assign half   = root >> 1;
  assign dtmp   = {rem_q, quo_q[NUM_W-1]};
  assign dge    = (dtmp >= {1'b0, den_q});
  assign satc   = (quo_q > COMP_SAT) ? 15'h7fff : quo_q[14:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      unique case (cmd_i.cap_sel)
        NB_C:    begin hc_q <= rdata; sum_q <= '0; end
        NB_W:    hw_q <= rdata;
        NB_E:    he_q <= rdata;
        NB_N:    hn_q <= rdata;
        NB_S:    hs_q <= rdata;
        default: ;
      endcase
      if (cmd_i.cap_sel != NB_C && rdata > hc_q) begin
        sum_q <= sum_q + SUM_W'(rdata - hc_q);
      end
    end
    if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_step)
        2'd0: begin
          mx_q   <= col_in ? {1'b0, px} : {px, 1'b0};
          mz_q   <= row_in ? {1'b0, pz} : {pz, 1'b0};
          negx_q <= (dx > 17'sd0);
          negz_q <= (dz > 17'sd0);
        end
        2'd1: sq_q <= mx_q * mx_q;
        2'd2: begin
          len_q <= LEN_W'(sq_q) + Y_SQ;
          sq_q  <= mz_q * mz_q;
        end
        default: len_q <= len_q + LEN_W'(sq_q);
      endcase
    end
    // one result bit per step
    if (cmd_i.sqrt_init) begin
      sv_q   <= len_q;
      sres_q <= '0;
      sbit_q <= SQ_BIT0;
    end else if (cmd_i.sqrt_step) begin
      if (sv_q >= strial) begin
        sv_q   <= sv_q - strial;
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
    // restoring divider, one quotient bit per step
    if (cmd_i.div_init) begin
      rem_q <= '0;
      den_q <= (cmd_i.div_sel == DIV_OCC) ? OCC_DEN : root;
      unique case (cmd_i.div_sel)
        DIV_X:   quo_q <= {2'b0, mx_q, 15'b0} + NUM_W'(half);
        DIV_Y:   quo_q <= {2'b0, Y_MAG, 15'b0} + NUM_W'(half);
        DIV_Z:   quo_q <= {2'b0, mz_q, 15'b0} + NUM_W'(half);
        default: quo_q <= NUM_W'({sum_q, 2'b0}) + NUM_W'(sum_q) + OCC_BIAS;
      endcase
    end else if (cmd_i.div_step) begin
      rem_q <= dge ? ROOT_W'(dtmp - {1'b0, den_q}) : dtmp[ROOT_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], dge};
    end
    if (cmd_i.div_store) begin
      unique case (cmd_i.div_sel)
        DIV_X:   nx_q <= negx_q ? -$signed({1'b0, satc}) : $signed({1'b0, satc});
        DIV_Y:   ny_q <= satc;
        DIV_Z:   nz_q <= negz_q ? -$signed({1'b0, satc}) : $signed({1'b0, satc});
        default: occ_q <= (quo_q > OCC_SAT) ? 16'hffff : quo_q[15:0];
      endcase
    end
    if (cmd_i.load_out) begin
      out_q.vertex_row  <= out_row_q;
      out_q.vertex_col  <= out_col_q;
      out_q.normal_x    <= nx_q;
      out_q.normal_y    <= ny_q;
      out_q.normal_z    <= nz_q;
      out_q.occlusion   <= occ_q;
      out_q.last_vertex <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* src/heightfield_normal_occlusion_unit.sv */
// Top level of the heightfield normal/occlusion unit.
// Depends on hno_pkg, hno_ctrl, hno_dpath (which holds hno_ram).
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o | in_item_i (op, sample_height)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (vertex, normal, occlusion)
//   config  | input     | APB psel/penable      | vertex_columns, vertex_rows, height_scale
//
// An item that yields no result leaves the sequencer idle. After an item that
// yields a result the next item can enter once the sequencer has run through
// the accept, 9 window reads, 4 multiply steps, a 26-step square root, four
// 42-step divisions on the one shared divider and the output load, which
// waits while a stalled earlier result holds the output register. The output
// register lets the next item enter while a result waits on a stall. Reset is
// asynchronous; the window RAM needs no clearing pass.
module heightfield_normal_occlusion_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hno_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  hno_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output hno_pkg::out_item_t         out_item_o
);
  import hno_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;
  logic       idle, in_acc;

  // new items only enter while the sequencer is idle
  assign in_stall_o = !idle;
  assign in_acc     = in_valid_i && idle;
  assign pready     = 1'b1;

  hno_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_acc_i (in_acc),
    .st_i     (st),
    .cmd_o    (cmd),
    .idle_o   (idle)
  );

  hno_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .in_acc_i    (in_acc),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  // an item that yields a result must make the block busy
  a_busy_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && st.emit_req |=> in_stall_o)
    else $error("block took no busy cycle after an emitting item");

  // the up component of a unit normal never reaches zero
  a_normal_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.normal_y != 15'd0)
    else $error("normal_y is zero");

endmodule
